// ----- hw/rtl/dbb_pkg.sv -----
// Shared types and constants for the binary de Bruijn bit generator.
`default_nettype none
package dbb_pkg;

	localparam int MAX_ORDER_DEF = 32;
	localparam int WL_W = 6;
	localparam logic [WL_W-1:0] WORD_LENGTH_RST = 6'd8;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [0:0] REG_WORD_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		PH_BODY = 2'd0,
		PH_TAIL = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMIT_RD,
		ST_EMIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SET,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_MOD_WAIT
	} state_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} mod_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dbb_digit_mem.sv -----
// Prenecklace digit store: one-bit memory with per-entry valid bits and a registered read.
`default_nettype none
module dbb_digit_mem #(
	parameter int Depth = 33,
	parameter int IW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire logic          we,
	input  wire logic [IW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic [IW-1:0] raddr,
	output logic               rdata
);
	import dbb_pkg::*;

	logic             mem [Depth];
	logic [Depth-1:0] valid_q;
	logic             rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// An entry never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] & mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/dbb_mod_unit.sv -----
// Iterative remainder unit: one compare and subtract per cycle.
`default_nettype none
module dbb_mod_unit #(
	parameter int W = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output dbb_pkg::mod_stat_t stat
);
	import dbb_pkg::*;

	logic [W-1:0] rem_q;
	logic [W-1:0] div_q;
	logic         busy_q;
	logic         below;

	assign below = rem_q < div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && below) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
		end else if (busy_q && !below) begin
			rem_q <= rem_q - div_q;
		end
	end

	assign stat.done     = busy_q & below;
	assign stat.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ----- hw/rtl/binary_de_bruijn_bit_generator.sv -----
// Binary de Bruijn bit generator: sequencer, registers and configuration port.
// The block hands out the linear binary de Bruijn sequence of order word_length,
// one bit per input word. An input word carries only restart; a 1 begins the
// sequence again before the bit is given. Each input word yields exactly one
// output word of seq_bit, last_bit and exhausted. Once the 2^n+n-1 bits are
// out, further requests return exhausted with a zero bit.
// A bit inside the current Lyndon word is read in ST_EMIT_RD and registered for
// output in ST_EMIT. The last bit of a word also steps to the next prenecklace:
// the digit scan and the copy each take a read and a check or write state per
// digit through the single read port of the digit store, and the divisibility
// test runs in the subtract-and-compare remainder unit; these repeat until a
// period dividing n is found or the body is complete. The block takes one word at
// a time: in_stall stays high from acceptance until the result has been taken, so
// a stall on the output holds the result and the input. Reset sets word_length to
// 8 and the sequence to its start; writing word_length also restarts it; the user
// must write it only while idle, as the block does not enforce this.
`default_nettype none
module binary_de_bruijn_bit_generator #(
	parameter int MAX_ORDER = dbb_pkg::MAX_ORDER_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dbb_pkg::APB_AW-1:0]   paddr,
	input  wire logic [dbb_pkg::APB_DW-1:0]   pwdata,
	output logic      [dbb_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         restart,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              seq_bit,
	output logic                              last_bit,
	output logic                              exhausted
);
	import dbb_pkg::*;

	localparam int IW = $clog2(MAX_ORDER + 1);
	localparam int Depth = MAX_ORDER + 1;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	logic [WL_W-1:0] word_length_q;
	logic [IW-1:0]   period_q, period_d;
	logic [IW-1:0]   emit_q, emit_d;
	logic [IW-1:0]   tail_q, tail_d;
	logic [IW-1:0]   j_q, j_d;
	logic [IW:0]     i_q, i_d;
	logic            out_valid_q, out_valid_d;
	logic            out_bit_q, out_bit_d;
	logic            out_last_q, out_last_d;
	logic            out_exh_q, out_exh_d;

	logic            cfg_wr;
	logic            in_acc;
	logic            restart_now;
	logic [IW-1:0]   order;
	logic [IW-1:0]   idx;

	logic            mem_clear;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic            mem_wdata;
	logic [IW-1:0]   mem_raddr;
	logic            mem_rdata;

	logic            mod_start;
	mod_stat_t       mod_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2:2] == REG_WORD_LENGTH);
	assign prdata = (paddr[2:2] == REG_WORD_LENGTH) ?
		{{(APB_DW-WL_W){1'b0}}, word_length_q} : '0;

	assign in_stall  = (state_q != ST_IDLE) | out_valid_q;
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign seq_bit   = out_bit_q;
	assign last_bit  = out_last_q;
	assign exhausted = out_exh_q;

	// Order zero acts as order one, and orders beyond the store are clamped.
	always_comb begin
		if (word_length_q == '0) begin
			order = IW'(1);
		end else if ({1'b0, word_length_q} > 7'(MAX_ORDER)) begin
			order = IW'(MAX_ORDER);
		end else begin
			order = IW'(word_length_q);
		end
	end

	always_comb begin
		if (emit_q == '0 || emit_q > order) begin
			idx = IW'(1);
		end else begin
			idx = emit_q;
		end
	end

	assign restart_now = cfg_wr | (in_acc & restart);
	assign mem_clear   = restart_now;

	dbb_digit_mem #(
		.Depth(Depth),
		.IW   (IW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (mem_clear),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dbb_mod_unit #(
		.W(IW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(order),
		.divisor (period_q),
		.stat    (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		period_d    = period_q;
		emit_d      = emit_q;
		tail_d      = tail_q;
		j_d         = j_q;
		i_d         = i_q;
		out_valid_d = out_valid_q & out_stall;
		out_bit_d   = out_bit_q;
		out_last_d  = out_last_q;
		out_exh_d   = out_exh_q;
		mem_we      = 1'b0;
		mem_waddr   = j_q;
		mem_wdata   = 1'b1;
		mem_raddr   = idx;
		mod_start   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (restart || phase_q == PH_BODY) begin
						state_d = ST_EMIT_RD;
					end else if (phase_q == PH_TAIL) begin
						out_valid_d = 1'b1;
						out_bit_d   = 1'b0;
						out_exh_d   = 1'b0;
						out_last_d  = 1'b0;
						tail_d      = tail_q + IW'(1);
						if (({1'b0, tail_q} + (IW+1)'(1)) >= ({1'b0, order} - (IW+1)'(1))) begin
							phase_d    = PH_DONE;
							out_last_d = 1'b1;
						end
					end else begin
						out_valid_d = 1'b1;
						out_bit_d   = 1'b0;
						out_last_d  = 1'b0;
						out_exh_d   = 1'b1;
					end
				end
			end
			ST_EMIT_RD: begin
				mem_raddr = idx;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				out_bit_d  = mem_rdata;
				out_last_d = 1'b0;
				out_exh_d  = 1'b0;
				if (idx < period_q) begin
					emit_d      = idx + IW'(1);
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					emit_d  = IW'(1);
					j_d     = order;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				mem_raddr = j_q;
				state_d   = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (!mem_rdata) begin
					state_d = ST_SET;
				end else if (j_q == IW'(1)) begin
					// No zero digit is left: the body is complete.
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
					if (order > IW'(1)) begin
						phase_d = PH_TAIL;
						tail_d  = '0;
					end else begin
						phase_d    = PH_DONE;
						out_last_d = 1'b1;
					end
				end else begin
					j_d     = j_q - IW'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_SET: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = 1'b1;
				period_d  = j_q;
				i_d       = (IW+1)'(j_q) + (IW+1)'(1);
				state_d   = ST_COPY_RD;
			end
			ST_COPY_RD: begin
				mem_raddr = IW'(i_q - (IW+1)'(j_q));
				if (i_q > (IW+1)'(order)) begin
					mod_start = 1'b1;
					state_d   = ST_MOD_WAIT;
				end else begin
					state_d = ST_COPY_WR;
				end
			end
			ST_COPY_WR: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[IW-1:0];
				mem_wdata = mem_rdata;
				i_d       = i_q + (IW+1)'(1);
				state_d   = ST_COPY_RD;
			end
			ST_MOD_WAIT: begin
				if (mod_stat.done) begin
					if (mod_stat.rem_zero) begin
						out_valid_d = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						j_d     = order;
						state_d = ST_SCAN_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A restart takes effect before the bit of the same word is worked out.
		if (restart_now) begin
			phase_d  = PH_BODY;
			period_d = IW'(1);
			emit_d   = IW'(1);
			tail_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= WORD_LENGTH_RST;
			phase_q       <= PH_BODY;
			period_q      <= IW'(1);
			emit_q        <= IW'(1);
			tail_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				word_length_q <= pwdata[WL_W-1:0];
			end
			phase_q     <= phase_d;
			period_q    <= period_d;
			emit_q      <= emit_d;
			tail_q      <= tail_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q        <= j_d;
		i_q        <= i_d;
		out_bit_q  <= out_bit_d;
		out_last_q <= out_last_d;
		out_exh_q  <= out_exh_d;
	end

endmodule
`default_nettype wire

// ----- tb/binary_de_bruijn_bit_generator_test.sv -----
// Self-checking testbench for the binary de Bruijn bit generator.
module binary_de_bruijn_bit_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dbb_pkg::*;

	localparam int RANDOM_REQUESTS = 725;
	localparam int CALM_REQUESTS = 100;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic seq_bit;
		logic last_bit;
		logic exhausted;
	} gen_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic seq_bit;
	logic last_bit;
	logic exhausted;

	logic pending_restarts[$];
	gen_word_t expected_words[$];
	gen_word_t taken_word;

	bit idle_on = 1'b1;
	int in_gap = 0;
	int out_hold = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int requests_taken = 0;
	int settings_written = 0;
	int last_seen = 0;
	int exhausted_seen = 0;

	// Own copy of the generator state.
	logic [WL_W-1:0] word_len = WORD_LENGTH_RST;
	logic [MAX_ORDER_DEF:0] digits = '0;
	int unsigned period_len = 1;
	int unsigned emit_pos = 1;
	int unsigned tail_cnt = 0;
	phase_t seq_phase = PH_BODY;

	binary_de_bruijn_bit_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.seq_bit(seq_bit),
		.last_bit(last_bit),
		.exhausted(exhausted)
	);

	always #4 clk = ~clk;

	function automatic int unsigned effective_order(input logic [WL_W-1:0] wl);
		if (wl == 0)
			return 1;
		if (wl > MAX_ORDER_DEF)
			return MAX_ORDER_DEF;
		return 32'(wl);
	endfunction

	function automatic void seq_restart();
		digits = '0;
		period_len = 1;
		emit_pos = 1;
		tail_cnt = 0;
		seq_phase = PH_BODY;
	endfunction

	// Steps the prenecklace to its successor; returns 0 once the last one is passed.
	function automatic bit advance_prenecklace(input int unsigned n);
		int unsigned j;
		int unsigned i;
		j = n;
		while (j > 0 && digits[j])
			j--;
		if (j == 0)
			return 1'b0;
		digits[j] = 1'b1;
		for (i = j + 1; i <= n; i++)
			digits[i] = digits[i - j];
		period_len = j;
		return 1'b1;
	endfunction

	function automatic gen_word_t predict_next_bit(input logic rs);
		gen_word_t r;
		int unsigned n;
		int unsigned idx;
		bit more;
		r = '0;
		if (rs)
			seq_restart();
		n = effective_order(word_len);
		case (seq_phase)
			PH_BODY: begin
				idx = emit_pos;
				if (idx < 1 || idx > n)
					idx = 1;
				r.seq_bit = digits[idx];
				if (idx < period_len) begin
					emit_pos = idx + 1;
				end else begin
					emit_pos = 1;
					// Only Lyndon words whose length divides the order are given out.
					do
						more = advance_prenecklace(n);
					while (more && (n % period_len) != 0);
					if (!more) begin
						if (n > 1) begin
							seq_phase = PH_TAIL;
							tail_cnt = 0;
						end else begin
							seq_phase = PH_DONE;
							r.last_bit = 1'b1;
						end
					end
				end
			end
			PH_TAIL: begin
				tail_cnt++;
				if (tail_cnt >= n - 1) begin
					seq_phase = PH_DONE;
					r.last_bit = 1'b1;
				end
			end
			default: begin
				r.exhausted = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: one request word at a time from the pending queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_words = {expected_words, predict_next_bit(restart)};
				requests_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_restarts.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 3) == 0) begin
					in_gap = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					restart <= pending_restarts[0];
					pending_restarts.delete(0);
				end
			end
		end
	end

	// Monitor: checks every result word taken and throttles the output side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %b%b%b",
						$time, seq_bit, last_bit, exhausted);
					mismatches++;
				end else begin
					taken_word = expected_words[0];
					expected_words.delete(0);
					check_field("seq_bit", taken_word.seq_bit, seq_bit);
					check_field("last_bit", taken_word.last_bit, last_bit);
					check_field("exhausted", taken_word.exhausted, exhausted);
					if (taken_word.last_bit)
						last_seen++;
					if (taken_word.exhausted)
						exhausted_seen++;
				end
			end
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_hold = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_restarts.size() != 0 || in_valid || expected_words.size() != 0);
	endtask

	task automatic set_order(input logic [WL_W-1:0] wl);
		logic [APB_DW-1:0] data;
		logic [APB_DW-1:0] rdata;
		wait_drained();
		data = $urandom;
		data[WL_W-1:0] = wl;
		apb_access(1'b1, {REG_WORD_LENGTH, 2'b00}, data, rdata);
		word_len = wl;
		seq_restart();
		settings_written++;
		apb_access(1'b0, {REG_WORD_LENGTH, 2'b00}, '0, rdata);
		if (rdata[WL_W-1:0] !== wl) begin
			$display("%0t: word_length readback mismatch, expected %0d, actual %0d",
				$time, wl, rdata[WL_W-1:0]);
			mismatches++;
		end
	endtask

	task automatic queue_requests(input int count, input int restart_odds);
		int k;
		for (k = 0; k < count; k++)
			pending_restarts = {pending_restarts, ($urandom_range(1, restart_odds) == 1)};
	endtask

	initial begin
		logic [APB_DW-1:0] rdata;
		logic [WL_W-1:0] wl;
		int unsigned n;
		int count;
		int random_requests;

		random_requests = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Order from reset, with a write to an unmapped register between words.
		pending_restarts = '{1'b1, 1'b0, 1'b0};
		wait_drained();
		apb_access(1'b1, 3'b100, $urandom, rdata);
		pending_restarts = '{1'b0, 1'b1, 1'b0};

		// Order zero acts as order one: two bits, then exhausted until restarted.
		set_order(6'd0);
		pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

		// Above the largest order the generator clamps.
		set_order(6'd63);
		pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

		// Order two, run past its end.
		set_order(6'd2);
		pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

		while (random_requests < RANDOM_REQUESTS) begin
			if (random_requests >= RANDOM_REQUESTS - CALM_REQUESTS)
				idle_on = 1'b0;
			case ($urandom_range(0, 15))
				0: wl = 6'd0;
				1: wl = 6'($urandom_range(33, 63));
				2: wl = 6'($urandom_range(9, 32));
				3: wl = 6'd7;
				default: wl = 6'($urandom_range(1, 6));
			endcase
			set_order(wl);
			n = effective_order(wl);
			// Short orders run to the end and beyond; long ones only show their start.
			if (n <= 8)
				count = (1 << n) + n - 1 + $urandom_range(1, 3);
			else
				count = $urandom_range(20, 60);
			queue_requests(count, 100);
			random_requests += count;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d request words through %0d word_length settings.",
			requests_taken, settings_written);
		$display("Saw %0d final-bit marks and %0d exhausted replies.", last_seen, exhausted_seen);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/dbb_pkg.sv
hw/rtl/dbb_digit_mem.sv
hw/rtl/dbb_mod_unit.sv
hw/rtl/binary_de_bruijn_bit_generator.sv
tb/binary_de_bruijn_bit_generator_test.sv
